/* src/rtn_pkg.sv */
// ----------------------------------------------------------------------------
// Ray-triangle nearest hit: shared package
// Payload structs, micro-step table, command and status groups, helpers.
// ----------------------------------------------------------------------------
package rtn_pkg;

	typedef struct packed {
		logic signed [31:0] a_x;
		logic signed [31:0] a_y;
		logic signed [31:0] a_z;
		logic signed [31:0] b_x;
		logic signed [31:0] b_y;
		logic signed [31:0] b_z;
		logic signed [31:0] c_x;
		logic signed [31:0] c_y;
		logic signed [31:0] c_z;
		logic               mesh_start;
	} tri_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] hit_dist;
		logic signed [31:0] bary_u;
		logic signed [31:0] bary_v;
		logic               any_hit;
		logic signed [31:0] nearest_dist;
		logic [15:0]        nearest_face;
	} res_t;

	typedef enum logic [2:0] {
		CFG_ORIGIN_X = 3'd0,
		CFG_ORIGIN_Y = 3'd1,
		CFG_ORIGIN_Z = 3'd2,
		CFG_DIR_X    = 3'd3,
		CFG_DIR_Y    = 3'd4,
		CFG_DIR_Z    = 3'd5,
		CFG_DET_EPS  = 3'd6
	} cfg_idx_t;

	typedef enum logic [4:0] {
		SRC_DX, SRC_DY, SRC_DZ,
		SRC_E1X, SRC_E1Y, SRC_E1Z,
		SRC_E2X, SRC_E2Y, SRC_E2Z,
		SRC_TVX, SRC_TVY, SRC_TVZ,
		SRC_PVX, SRC_PVY, SRC_PVZ,
		SRC_QVX, SRC_QVY, SRC_QVZ
	} src_t;

	typedef enum logic [3:0] {
		DST_PVX, DST_PVY, DST_PVZ, DST_DET, DST_U,
		DST_QVX, DST_QVY, DST_QVZ, DST_V, DST_T
	} dst_t;

	typedef struct packed {
		src_t a;
		src_t b;
		logic neg;
		logic last;
		dst_t dst;
	} uop_t;

	localparam logic [4:0] STEP_U_FIRST = 5'd9;
	localparam logic [4:0] STEP_Q_FIRST = 5'd12;
	localparam logic [4:0] STEP_T_FIRST = 5'd21;
	localparam logic [4:0] STEP_LAST    = 5'd23;

	localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;

	typedef struct packed {
		logic       load;
		logic       mul;
		logic       acc;
		logic [4:0] step;
		logic       div_start;
		logic       finish;
		logic       hit;
	} cmd_t;

	typedef struct packed {
		logic det_ok;
		logic u_ok;
		logic v_ok;
		logic div_done;
	} sts_t;

	function automatic uop_t uop(input logic [4:0] step);
		uop_t r;
		r = '{a: SRC_DX, b: SRC_DX, neg: 1'b0, last: 1'b0, dst: DST_PVX};
		unique case (step)
			5'd0:  r = '{SRC_DY,  SRC_E2Z, 1'b0, 1'b0, DST_PVX};
			5'd1:  r = '{SRC_DZ,  SRC_E2Y, 1'b1, 1'b1, DST_PVX};
			5'd2:  r = '{SRC_DZ,  SRC_E2X, 1'b0, 1'b0, DST_PVY};
			5'd3:  r = '{SRC_DX,  SRC_E2Z, 1'b1, 1'b1, DST_PVY};
			5'd4:  r = '{SRC_DX,  SRC_E2Y, 1'b0, 1'b0, DST_PVZ};
			5'd5:  r = '{SRC_DY,  SRC_E2X, 1'b1, 1'b1, DST_PVZ};
			5'd6:  r = '{SRC_E1X, SRC_PVX, 1'b0, 1'b0, DST_DET};
			5'd7:  r = '{SRC_E1Y, SRC_PVY, 1'b0, 1'b0, DST_DET};
			5'd8:  r = '{SRC_E1Z, SRC_PVZ, 1'b0, 1'b1, DST_DET};
			5'd9:  r = '{SRC_TVX, SRC_PVX, 1'b0, 1'b0, DST_U};
			5'd10: r = '{SRC_TVY, SRC_PVY, 1'b0, 1'b0, DST_U};
			5'd11: r = '{SRC_TVZ, SRC_PVZ, 1'b0, 1'b1, DST_U};
			5'd12: r = '{SRC_TVY, SRC_E1Z, 1'b0, 1'b0, DST_QVX};
			5'd13: r = '{SRC_TVZ, SRC_E1Y, 1'b1, 1'b1, DST_QVX};
			5'd14: r = '{SRC_TVZ, SRC_E1X, 1'b0, 1'b0, DST_QVY};
			5'd15: r = '{SRC_TVX, SRC_E1Z, 1'b1, 1'b1, DST_QVY};
			5'd16: r = '{SRC_TVX, SRC_E1Y, 1'b0, 1'b0, DST_QVZ};
			5'd17: r = '{SRC_TVY, SRC_E1X, 1'b1, 1'b1, DST_QVZ};
			5'd18: r = '{SRC_DX,  SRC_QVX, 1'b0, 1'b0, DST_V};
			5'd19: r = '{SRC_DY,  SRC_QVY, 1'b0, 1'b0, DST_V};
			5'd20: r = '{SRC_DZ,  SRC_QVZ, 1'b0, 1'b1, DST_V};
			5'd21: r = '{SRC_E2X, SRC_QVX, 1'b0, 1'b0, DST_T};
			5'd22: r = '{SRC_E2Y, SRC_QVY, 1'b0, 1'b0, DST_T};
			5'd23: r = '{SRC_E2Z, SRC_QVZ, 1'b0, 1'b1, DST_T};
			default: r = '{SRC_DX, SRC_DX, 1'b0, 1'b0, DST_PVX};
		endcase
		return r;
	endfunction

	function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
		logic signed [31:0] r;
		if (x > 64'sh0000_0000_7FFF_FFFF) begin
			r = 32'sh7FFF_FFFF;
		end else if (x < -64'sh0000_0000_8000_0000) begin
			r = 32'sh8000_0000;
		end else begin
			r = x[31:0];
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sub_sat(input logic signed [31:0] a,
			input logic signed [31:0] b);
		return sat32(64'(a) - 64'(b));
	endfunction

endpackage

/* src/rtn_div.sv */
// ----------------------------------------------------------------------------
// Ray-triangle nearest hit: restoring divider lane
// Unsigned division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module rtn_div #(
	parameter int W = 48
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [31:0]  den,
	output logic         done,
	output logic [W-1:0] quo
);

	localparam int CW = $clog2(W + 1);

	logic [31:0]   rem_q;
	logic [W-1:0]  num_q;
	logic [31:0]   den_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic [32:0]   trial;
	logic          bit_ok;

	assign trial  = {rem_q, num_q[W-1]};
	assign bit_ok = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CW'(W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			num_q <= num;
			den_q <= den;
		end else if (busy_q) begin
			rem_q <= bit_ok ? 32'(trial - {1'b0, den_q}) : trial[31:0];
			num_q <= {num_q[W-2:0], bit_ok};
		end
	end

	assign done = !busy_q;
	assign quo  = num_q;

endmodule

/* src/rtn_dp.sv */
// ----------------------------------------------------------------------------
// Ray-triangle nearest hit: datapath
// Ray registers, vector registers, shared multiplier and accumulator,
// three divider lanes, nearest-hit tracking and the result register.
// ----------------------------------------------------------------------------
module rtn_dp #(
	parameter int FACE_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data,
	input  logic               in_we,
	input  rtn_pkg::tri_t      in_data,
	input  rtn_pkg::cmd_t      cmd,
	output rtn_pkg::sts_t      sts,
	output rtn_pkg::res_t      res
);

	localparam int DW = 32 + FRAC_BITS;

	logic signed [31:0] ox_q, oy_q, oz_q, dx_q, dy_q, dz_q;
	logic [30:0]        eps_q;
	rtn_pkg::tri_t      tri_q;
	logic signed [31:0] e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q;
	logic signed [31:0] tvx_q, tvy_q, tvz_q, pvx_q, pvy_q, pvz_q;
	logic signed [31:0] qvx_q, qvy_q, qvz_q, u_q, v_q, t_q;
	logic [31:0]        det_q;
	logic signed [63:0] prod_s1;
	logic signed [63:0] acc_q, acc_next, term;
	logic signed [31:0] wb, opa, opb;
	rtn_pkg::uop_t      op;
	logic signed [31:0] best_dist_q;
	logic [FACE_BITS-1:0] best_face_q, face_q;
	logic               seen_q;
	rtn_pkg::res_t      res_q;
	logic [31:0]        t_mag, u_mag, v_mag;
	logic [DW-1:0]      t_quo, u_quo, v_quo;
	logic               t_done, u_done, v_done;
	logic signed [31:0] hd, bu, bv;
	logic               take;
	logic signed [31:0] nd;
	logic [FACE_BITS-1:0] nf;
	logic [31:0]        nf_ext;

	assign op = rtn_pkg::uop(cmd.step);

	function automatic logic signed [31:0] qsat(input logic neg, input logic [DW-1:0] q);
		logic signed [31:0] r;
		if (!neg) begin
			r = (|q[DW-1:31]) ? 32'sh7FFF_FFFF : $signed(q[31:0]);
		end else begin
			r = ((|q[DW-1:32]) || (q[31] && (|q[30:0]))) ? 32'sh8000_0000 :
				$signed(32'(-q[31:0]));
		end
		return r;
	endfunction

	function automatic logic signed [31:0] sel(input rtn_pkg::src_t s,
			input logic signed [31:0] d0, input logic signed [31:0] d1,
			input logic signed [31:0] d2, input logic signed [31:0] a0,
			input logic signed [31:0] a1, input logic signed [31:0] a2,
			input logic signed [31:0] b0, input logic signed [31:0] b1,
			input logic signed [31:0] b2, input logic signed [31:0] t0,
			input logic signed [31:0] t1, input logic signed [31:0] t2,
			input logic signed [31:0] p0, input logic signed [31:0] p1,
			input logic signed [31:0] p2, input logic signed [31:0] q0,
			input logic signed [31:0] q1, input logic signed [31:0] q2);
		logic signed [31:0] r;
		unique case (s)
			rtn_pkg::SRC_DX:  r = d0;
			rtn_pkg::SRC_DY:  r = d1;
			rtn_pkg::SRC_DZ:  r = d2;
			rtn_pkg::SRC_E1X: r = a0;
			rtn_pkg::SRC_E1Y: r = a1;
			rtn_pkg::SRC_E1Z: r = a2;
			rtn_pkg::SRC_E2X: r = b0;
			rtn_pkg::SRC_E2Y: r = b1;
			rtn_pkg::SRC_E2Z: r = b2;
			rtn_pkg::SRC_TVX: r = t0;
			rtn_pkg::SRC_TVY: r = t1;
			rtn_pkg::SRC_TVZ: r = t2;
			rtn_pkg::SRC_PVX: r = p0;
			rtn_pkg::SRC_PVY: r = p1;
			rtn_pkg::SRC_PVZ: r = p2;
			rtn_pkg::SRC_QVX: r = q0;
			rtn_pkg::SRC_QVY: r = q1;
			rtn_pkg::SRC_QVZ: r = q2;
			default:          r = d0;
		endcase
		return r;
	endfunction

	always_comb begin
		opa = sel(op.a, dx_q, dy_q, dz_q, e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q,
			tvx_q, tvy_q, tvz_q, pvx_q, pvy_q, pvz_q, qvx_q, qvy_q, qvz_q);
		opb = sel(op.b, dx_q, dy_q, dz_q, e1x_q, e1y_q, e1z_q, e2x_q, e2y_q, e2z_q,
			tvx_q, tvy_q, tvz_q, pvx_q, pvy_q, pvz_q, qvx_q, qvy_q, qvz_q);
		term     = op.neg ? -(prod_s1 >>> FRAC_BITS) : (prod_s1 >>> FRAC_BITS);
		acc_next = acc_q + term;
		wb       = rtn_pkg::sat32(acc_next);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ox_q  <= '0;
			oy_q  <= '0;
			oz_q  <= '0;
			dx_q  <= '0;
			dy_q  <= '0;
			dz_q  <= 32'sd65536;
			eps_q <= 31'd7;
		end else if (cfg_we) begin
			case (cfg_index)
				rtn_pkg::CFG_ORIGIN_X: ox_q  <= $signed(cfg_data);
				rtn_pkg::CFG_ORIGIN_Y: oy_q  <= $signed(cfg_data);
				rtn_pkg::CFG_ORIGIN_Z: oz_q  <= $signed(cfg_data);
				rtn_pkg::CFG_DIR_X:    dx_q  <= $signed(cfg_data);
				rtn_pkg::CFG_DIR_Y:    dy_q  <= $signed(cfg_data);
				rtn_pkg::CFG_DIR_Z:    dz_q  <= $signed(cfg_data);
				rtn_pkg::CFG_DET_EPS:  eps_q <= cfg_data[30:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_we) begin
			tri_q <= in_data;
		end
		if (cmd.load) begin
			e1x_q <= rtn_pkg::sub_sat(tri_q.b_x, tri_q.a_x);
			e1y_q <= rtn_pkg::sub_sat(tri_q.b_y, tri_q.a_y);
			e1z_q <= rtn_pkg::sub_sat(tri_q.b_z, tri_q.a_z);
			e2x_q <= rtn_pkg::sub_sat(tri_q.c_x, tri_q.a_x);
			e2y_q <= rtn_pkg::sub_sat(tri_q.c_y, tri_q.a_y);
			e2z_q <= rtn_pkg::sub_sat(tri_q.c_z, tri_q.a_z);
			acc_q <= '0;
		end
		if (cmd.mul) begin
			prod_s1 <= opa * opb;
		end
		if (cmd.acc) begin
			acc_q <= op.last ? 64'sd0 : acc_next;
			if (op.last) begin
				case (op.dst)
					rtn_pkg::DST_PVX: pvx_q <= wb;
					rtn_pkg::DST_PVY: pvy_q <= wb;
					rtn_pkg::DST_PVZ: pvz_q <= wb;
					rtn_pkg::DST_DET: begin
						det_q <= wb[31] ? 32'(-wb) : 32'(wb);
						if (wb > 32'sd0) begin
							tvx_q <= rtn_pkg::sub_sat(ox_q, tri_q.a_x);
							tvy_q <= rtn_pkg::sub_sat(oy_q, tri_q.a_y);
							tvz_q <= rtn_pkg::sub_sat(oz_q, tri_q.a_z);
						end else begin
							tvx_q <= rtn_pkg::sub_sat(tri_q.a_x, ox_q);
							tvy_q <= rtn_pkg::sub_sat(tri_q.a_y, oy_q);
							tvz_q <= rtn_pkg::sub_sat(tri_q.a_z, oz_q);
						end
					end
					rtn_pkg::DST_U:   u_q   <= wb;
					rtn_pkg::DST_QVX: qvx_q <= wb;
					rtn_pkg::DST_QVY: qvy_q <= wb;
					rtn_pkg::DST_QVZ: qvz_q <= wb;
					rtn_pkg::DST_V:   v_q   <= wb;
					rtn_pkg::DST_T:   t_q   <= wb;
					default: ;
				endcase
			end
		end
	end

	assign sts.det_ok = (det_q != 32'd0) && (det_q >= {1'b0, eps_q});
	assign sts.u_ok   = !u_q[31] && ($unsigned(u_q) <= det_q);
	assign sts.v_ok   = !v_q[31] && ((33'($unsigned(u_q)) + 33'($unsigned(v_q))) <= 33'(det_q));
	assign sts.div_done = t_done && u_done && v_done;

	assign t_mag = t_q[31] ? 32'(-t_q) : 32'(t_q);
	assign u_mag = u_q[31] ? 32'(-u_q) : 32'(u_q);
	assign v_mag = v_q[31] ? 32'(-v_q) : 32'(v_q);

	rtn_div #(.W(DW)) u_div_t (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num({t_mag, {FRAC_BITS{1'b0}}}), .den(det_q), .done(t_done), .quo(t_quo)
	);
	rtn_div #(.W(DW)) u_div_u (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num({u_mag, {FRAC_BITS{1'b0}}}), .den(det_q), .done(u_done), .quo(u_quo)
	);
	rtn_div #(.W(DW)) u_div_v (
		.clk(clk), .arst_n(arst_n), .start(cmd.div_start),
		.num({v_mag, {FRAC_BITS{1'b0}}}), .den(det_q), .done(v_done), .quo(v_quo)
	);

	always_comb begin
		hd     = cmd.hit ? qsat(t_q[31], t_quo) : 32'sd0;
		bu     = cmd.hit ? qsat(u_q[31], u_quo) : 32'sd0;
		bv     = cmd.hit ? qsat(v_q[31], v_quo) : 32'sd0;
		take   = cmd.hit && (!seen_q || (hd < best_dist_q));
		nd     = take ? hd : best_dist_q;
		nf     = take ? face_q : best_face_q;
		nf_ext = 32'(nf);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_dist_q <= rtn_pkg::DIST_MAX;
			best_face_q <= '0;
			face_q      <= '0;
			seen_q      <= 1'b0;
		end else if (cmd.load && tri_q.mesh_start) begin
			best_dist_q <= rtn_pkg::DIST_MAX;
			best_face_q <= '0;
			face_q      <= '0;
			seen_q      <= 1'b0;
		end else if (cmd.finish) begin
			best_dist_q <= nd;
			best_face_q <= nf;
			face_q      <= face_q + 1'b1;
			seen_q      <= seen_q || cmd.hit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			res_q.hit          <= cmd.hit;
			res_q.hit_dist     <= hd;
			res_q.bary_u       <= bu;
			res_q.bary_v       <= bv;
			res_q.any_hit      <= seen_q || cmd.hit;
			res_q.nearest_dist <= nd;
			res_q.nearest_face <= nf_ext[15:0];
		end
	end

	assign res = res_q;

endmodule

/* src/rtn_ctrl.sv */
// ----------------------------------------------------------------------------
// Ray-triangle nearest hit: controller
// Sequences the micro-steps, early rejection, division and result hand-off.
// ----------------------------------------------------------------------------
module rtn_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  rtn_pkg::sts_t sts,
	output rtn_pkg::cmd_t cmd
);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_LOAD = 7'b0000010,
		ST_MUL  = 7'b0000100,
		ST_ACC  = 7'b0001000,
		ST_DIVS = 7'b0010000,
		ST_DIV  = 7'b0100000,
		ST_FIN  = 7'b1000000
	} state_t;

	state_t     state_q;
	logic [4:0] step_q;
	logic       hit_q;
	logic       out_valid_q;
	logic       reject;
	logic       fire;

	assign reject = ((step_q == rtn_pkg::STEP_U_FIRST) && !sts.det_ok) ||
		((step_q == rtn_pkg::STEP_Q_FIRST) && !sts.u_ok) ||
		((step_q == rtn_pkg::STEP_T_FIRST) && !sts.v_ok);
	assign fire = (state_q == ST_FIN) && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			hit_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_LOAD;
				ST_LOAD: begin
					step_q  <= '0;
					state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (reject) begin
						hit_q   <= 1'b0;
						state_q <= ST_FIN;
					end else begin
						state_q <= ST_ACC;
					end
				end
				ST_ACC: begin
					if (step_q == rtn_pkg::STEP_LAST) begin
						state_q <= ST_DIVS;
					end else begin
						step_q  <= step_q + 1'b1;
						state_q <= ST_MUL;
					end
				end
				ST_DIVS: state_q <= ST_DIV;
				ST_DIV: begin
					if (sts.div_done) begin
						hit_q   <= 1'b1;
						state_q <= ST_FIN;
					end
				end
				ST_FIN: if (fire) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		cmd.load      = state_q == ST_LOAD;
		cmd.mul       = (state_q == ST_MUL) && !reject;
		cmd.acc       = state_q == ST_ACC;
		cmd.step      = step_q;
		cmd.div_start = state_q == ST_DIVS;
		cmd.finish    = fire;
		cmd.hit       = hit_q;
	end

	assign in_ready  = state_q == ST_IDLE;
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ST_LOAD)
		else $error("accepted triangle did not start loading");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_FIN && out_valid_q && !out_ready |=> state_q == ST_FIN)
		else $error("result overwritten while the previous one waits");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> out_valid_q)
		else $error("finished result not presented");
	a_hit_divided: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DIV && sts.div_done |=> hit_q)
		else $error("hit flag lost after division");
`endif

endmodule

/* src/ray_triangle_nearest_hit.sv */
// ----------------------------------------------------------------------------
// Ray-triangle nearest hit
// Moller-Trumbore test of one configured ray against a stream of triangles,
// with nearest-hit tracking per mesh.
// ----------------------------------------------------------------------------
// Channel  Signals                          Transaction
// in       in_valid, in_ready, in_data      one triangle (tri_t)
// out      out_valid, out_ready, out_data   one result (res_t)
// cfg      cfg_valid, cfg_ready, cfg_index, cfg_data   one register write
//
// A triangle is rejected early when det, u or v fails its check; a hit
// runs all 24 shared multiply and accumulate steps, each a multiply state
// followed by an accumulate state, then three divider lanes in parallel.
// One triangle is in work at a time; a finished result waits in the output
// register and only the next result's hand-off stalls on out_ready.
// Reset is asynchronous and restores the ray registers and mesh tracking.
// ----------------------------------------------------------------------------
module ray_triangle_nearest_hit #(
	parameter int FACE_BITS = 16,
	parameter int FRAC_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rtn_pkg::tri_t in_data,
	output logic          out_valid,
	input  logic          out_ready,
	output rtn_pkg::res_t out_data,
	input  logic          cfg_valid,
	output logic          cfg_ready,
	input  logic [2:0]    cfg_index,
	input  logic [31:0]   cfg_data
);

	rtn_pkg::cmd_t cmd;
	rtn_pkg::sts_t sts;

	assign cfg_ready = 1'b1;

	rtn_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.out_valid(out_valid), .out_ready(out_ready),
		.sts(sts), .cmd(cmd)
	);

	rtn_dp #(.FACE_BITS(FACE_BITS), .FRAC_BITS(FRAC_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_valid && cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_we(in_valid && in_ready), .in_data(in_data),
		.cmd(cmd), .sts(sts), .res(out_data)
	);

endmodule
